// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sliding median filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- sv/smf_pkg.sv -----
// Package with constants, sequencer states and control structs of the median filter
package smf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_WINDOW   = 16;
    localparam int CFG_WIDTH    = 5;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CAND,
        ST_LATCH,
        ST_SCAN,
        ST_EMIT
    } smf_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } smf_rank_ctrl_t;

    typedef struct packed
    {
        logic hit;
    } smf_rank_stat_t;

endpackage

// ----- sv/smf_if.sv -----
// Valid/ready stream interfaces for samples in and medians out
interface smf_sample_if #(parameter int DW = smf_pkg::SAMPLE_WIDTH);
    logic          valid;
    logic          ready;
    logic [DW-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smf_median_if #(parameter int DW = smf_pkg::SAMPLE_WIDTH);
    logic          valid;
    logic          ready;
    logic [DW-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// ----- sv/sliding_median_filter.sv -----
// Sliding-window median filter top level: window store, rank unit and sequencer
// Pass-through (window size 0): the sample is held in res_reg, then moves to the output register.
// Median of c stored samples: each candidate is read (CAND), latched (LATCH) and compared with
// all c samples (SCAN); a rejected candidate is followed by the next, on the single shared compare unit.
// The next sample transfer waits until the result has been taken into the output register.
// Reset clears window size, pointer, full flag and handshakes; the store is never read unwritten.
`include "assert_macros.svh"

module sliding_median_filter #(
    parameter int MAX_WINDOW   = smf_pkg::MAX_WINDOW
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [smf_pkg::CFG_WIDTH-1:0] cfg_wdata,
    smf_sample_if.sink                   samples,
    smf_median_if.source                 medians
);

    localparam int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    smf_pkg::smf_state_t state_reg;
    smf_pkg::smf_state_t state_next;

    logic [smf_pkg::CFG_WIDTH-1:0] window_size_reg;
    logic [smf_pkg::CFG_WIDTH-1:0] window_size_next;
    logic [AW-1:0]                 ptr_reg;
    logic [AW-1:0]                 ptr_next;
    logic                          full_reg;
    logic                          full_next;
    logic [AW-1:0]                 i_reg;
    logic [AW-1:0]                 i_next;
    logic [AW-1:0]                 j_reg;
    logic [AW-1:0]                 j_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 k_reg;
    logic [CW-1:0]                 k_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] res_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_next;
    logic [SAMPLE_WIDTH-1:0]       median_reg;
    logic [SAMPLE_WIDTH-1:0]       median_next;

    logic [CW-1:0]                 eff;
    logic [AW-1:0]                 ptr_base;
    logic [CW-1:0]                 ptr_inc;
    logic                          wrap;
    logic [CW-1:0]                 cnt;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          last;

    logic                          ram_we;
    logic [AW-1:0]                 ram_raddr;
    logic signed [SAMPLE_WIDTH-1:0] ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0] cand;

    smf_pkg::smf_rank_ctrl_t rank_ctrl;
    smf_pkg::smf_rank_stat_t rank_stat;

    assign in_xfer  = samples.valid && samples.ready;
    assign out_xfer = medians.valid && medians.ready;

    assign samples.ready = (state_reg == smf_pkg::ST_IDLE);
    assign medians.valid = out_valid_reg;
    assign medians.median = median_reg;

    always_comb
    begin
        if (32'(window_size_reg) > MAX_WINDOW)
        begin
            eff = CW'(MAX_WINDOW);
        end
        else
        begin
            eff = CW'(window_size_reg);
        end
        ptr_base = (CW'(ptr_reg) >= eff) ? '0 : ptr_reg;
        ptr_inc  = CW'(ptr_base) + CW'(1);
        wrap     = (ptr_inc >= eff);
        cnt      = wrap ? eff : ptr_inc;
        if (full_reg)
        begin
            cnt = eff;
        end
        if (cnt == '0)
        begin
            cnt = CW'(1);
        end
    end

    assign ram_we = in_xfer && (window_size_reg != '0);
    assign last   = ((CW'(j_reg) + CW'(1)) == count_reg);

    assign rank_ctrl.load = (state_reg == smf_pkg::ST_LATCH);
    assign rank_ctrl.step = (state_reg == smf_pkg::ST_SCAN);

    smf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_base),
        .wdata (SAMPLE_WIDTH'(samples.sample)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smf_rank_unit #(
        .DW (SAMPLE_WIDTH),
        .CW (CW)
    ) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rank_ctrl),
        .rdata (ram_rdata),
        .k     (k_reg),
        .cand  (cand),
        .stat  (rank_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        ptr_next         = ptr_reg;
        full_next        = full_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        res_next         = res_reg;
        median_next      = median_reg;
        out_valid_next   = out_valid_reg;
        ram_raddr        = '0;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            smf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (window_size_reg == '0)
                    begin
                        res_next   = SAMPLE_WIDTH'(samples.sample);
                        state_next = smf_pkg::ST_EMIT;
                    end
                    else
                    begin
                        ptr_next   = wrap ? '0 : AW'(ptr_inc);
                        full_next  = full_reg || wrap;
                        count_next = cnt;
                        k_next     = cnt >> 1;
                        i_next     = '0;
                        state_next = smf_pkg::ST_CAND;
                    end
                end
            end
            smf_pkg::ST_CAND:
            begin
                ram_raddr  = i_reg;
                state_next = smf_pkg::ST_LATCH;
            end
            smf_pkg::ST_LATCH:
            begin
                ram_raddr  = '0;
                j_next     = '0;
                state_next = smf_pkg::ST_SCAN;
            end
            smf_pkg::ST_SCAN:
            begin
                ram_raddr = j_reg + AW'(1);
                if (last)
                begin
                    if (rank_stat.hit)
                    begin
                        res_next   = cand;
                        state_next = smf_pkg::ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = smf_pkg::ST_CAND;
                    end
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            smf_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || medians.ready)
                begin
                    out_valid_next = 1'b1;
                    median_next    = res_reg;
                    state_next     = smf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smf_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            window_size_next = cfg_wdata;
            ptr_next         = '0;
            full_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= smf_pkg::ST_IDLE;
            window_size_reg <= '0;
            ptr_reg         <= '0;
            full_reg        <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            count_reg       <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            ptr_reg         <= ptr_next;
            full_reg        <= full_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            count_reg       <= count_next;
            k_reg           <= k_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        median_reg <= median_next;
    end

    `ASSERT_AT(a_busy_after_xfer, clk, rst_n, (in_xfer && window_size_reg != '0) |=> !samples.ready, "filter took a sample while ranking")
    `ASSERT_NEVER(a_scan_in_range, clk, rst_n, (state_reg == smf_pkg::ST_SCAN) && (CW'(j_reg) >= count_reg), "scan index ran past the window")
    `ASSERT_NEVER(a_cand_in_range, clk, rst_n, (state_reg == smf_pkg::ST_CAND) && (CW'(i_reg) >= count_reg), "no candidate matched the median rank")
    `ASSERT_NEVER(a_ptr_in_window, clk, rst_n, (window_size_reg != '0) && (CW'(ptr_reg) >= eff), "write pointer outside the window")

endmodule

// ----- sv/smf_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module smf_ram #(
    parameter int WIDTH = smf_pkg::SAMPLE_WIDTH,
    parameter int DEPTH = smf_pkg::MAX_WINDOW
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/smf_rank_unit.sv -----
// Shared compare unit that ranks one candidate sample against the window
module smf_rank_unit #(
    parameter int DW = smf_pkg::SAMPLE_WIDTH,
    parameter int CW = $clog2(smf_pkg::MAX_WINDOW + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smf_pkg::smf_rank_ctrl_t ctrl,
    input  logic signed [DW-1:0]  rdata,
    input  logic [CW-1:0]         k,
    output logic signed [DW-1:0]  cand,
    output smf_pkg::smf_rank_stat_t stat
);

    logic signed [DW-1:0] cand_reg;
    logic [CW-1:0]        less_reg;
    logic [CW-1:0]        less_next;
    logic [CW-1:0]        leq_reg;
    logic [CW-1:0]        leq_next;
    logic [CW-1:0]        less_sum;
    logic [CW-1:0]        leq_sum;

    assign less_sum = less_reg + CW'(rdata < cand_reg);
    assign leq_sum  = leq_reg + CW'(rdata <= cand_reg);

    always_comb
    begin
        less_next = less_reg;
        leq_next  = leq_reg;
        if (ctrl.load)
        begin
            less_next = '0;
            leq_next  = '0;
        end
        else if (ctrl.step)
        begin
            less_next = less_sum;
            leq_next  = leq_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= '0;
            leq_reg  <= '0;
        end
        else
        begin
            less_reg <= less_next;
            leq_reg  <= leq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cand_reg <= rdata;
        end
    end

    assign cand     = cand_reg;
    assign stat.hit = (less_sum <= k) && (k < leq_sum);

endmodule
